[rtl/core/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and the CRC-16 byte update for the packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Header bytes that open every framed packet
  localparam logic [7:0] HDR_BYTE0 = 8'hFF;
  localparam logic [7:0] HDR_BYTE1 = 8'hFF;
  localparam logic [7:0] HDR_BYTE2 = 8'hFD;
  localparam logic [7:0] HDR_BYTE3 = 8'h00;

  localparam logic [15:0] CRC_POLY       = 16'h8005;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd1024;
  localparam logic [15:0] MIN_LEN        = 16'd2;

  // One output word
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       err;
  } out_word_t;

  // CRC-16, MSB first, no reflection: fold in one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/spf_out_stage.sv]
// ----------------------------------------------------------------------------
// spf_out_stage
// Output register for the framer: holds one word until the receiver takes it.
// ----------------------------------------------------------------------------
module spf_out_stage
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  out_word_t  push_word,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       end_of_packet,
  output logic       status
);

  out_word_t word;

  // Free when empty or when the held word leaves this cycle
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      word <= push_word;
    end
  end

  assign out_byte      = word.data;
  assign end_of_packet = word.eop;
  assign status        = word.err;

endmodule

[rtl/core/servo_packet_framer_crc16.sv]
// ----------------------------------------------------------------------------
// servo_packet_framer_crc16
// Frames servo instruction packets with header and trailing CRC-16.
// ----------------------------------------------------------------------------
// Input channel body_*: packet body, one byte per word (ID, length low,
// length high, instruction, parameters). Output channel out_*: framed bytes
// with end_of_packet on the last CRC byte or the error word; status set on a length error.
// Config channel cfg_*: writes max_length; cfg_ready is always high.
// A body word is latched in an input register and worked off by a sequencer
// that emits one output word per cycle, while the output register is ready,
// into the output register; a word passes both registers on its way out.
// Throughput: one body byte per cycle in the body of a packet unless the
// output stalls. The length high byte holds the input while the header, ID
// and length go out (the CRC too when the length is 2); the last body byte
// holds it for the CRC. ID, length low and discarded bytes produce nothing.
// Reset: expects an ID byte, CRC and counters cleared, max_length = 1024.
// When the receiver stalls, the output word holds and the sequencer waits;
// body_stall rises once the input register cannot be retired.
// ----------------------------------------------------------------------------
module servo_packet_framer_crc16
  import spf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        body_valid,
  output logic        body_stall,
  input  logic [7:0]  body_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        end_of_packet,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_length
);

  localparam logic [2:0] PH_ID      = 3'd0;
  localparam logic [2:0] PH_LEN_LO  = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_BODY    = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  logic [15:0] max_len;
  logic [2:0]  phase, phase_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_len_low, held_len_low_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] crc, crc_next;
  logic [3:0]  step, step_next;
  logic        item_valid;
  logic [7:0]  item_byte;

  logic        emit;
  logic        done;
  logic        out_ready;
  out_word_t   word;
  logic [15:0] len;
  logic [15:0] crc_base;

  assign cfg_ready = 1'b1;

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= max_length;
    end
  end

  // Input register: refilled when empty or when the held word retires
  assign body_stall = item_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!body_stall) begin
      item_valid <= body_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!body_stall && body_valid) begin
      item_byte <= body_byte;
    end
  end

  assign len      = {item_byte, held_len_low};
  assign crc_base = (step == 4'd0) ? 16'h0000 : crc;

  // Sequencer: one output word per cycle for the held input word while the output register is ready
  always_comb begin
    emit              = 1'b0;
    done              = 1'b0;
    word              = '0;
    phase_next        = phase;
    held_id_next      = held_id;
    held_len_low_next = held_len_low;
    bytes_left_next   = bytes_left;
    crc_next          = crc;
    step_next         = step;
    if (item_valid) begin
      unique case (phase)
        PH_LEN_LO: begin
          held_len_low_next = item_byte;
          phase_next        = PH_LEN_HI;
          done              = 1'b1;
        end
        PH_LEN_HI: begin
          if (len < MIN_LEN) begin
            emit     = 1'b1;
            word.eop = 1'b1;
            word.err = 1'b1;
            if (out_ready) begin
              phase_next = PH_ID;
              done       = 1'b1;
            end
          end else if (len > max_len) begin
            emit     = 1'b1;
            word.eop = 1'b1;
            word.err = 1'b1;
            if (out_ready) begin
              bytes_left_next = len - MIN_LEN;
              phase_next      = (len == MIN_LEN) ? PH_ID : PH_DISCARD;
              done            = 1'b1;
            end
          end else begin
            emit = 1'b1;
            case (step)
              4'd0:    word.data = HDR_BYTE0;
              4'd1:    word.data = HDR_BYTE1;
              4'd2:    word.data = HDR_BYTE2;
              4'd3:    word.data = HDR_BYTE3;
              4'd4:    word.data = held_id;
              4'd5:    word.data = held_len_low;
              4'd6:    word.data = item_byte;
              4'd7:    word.data = crc[7:0];
              default: begin
                word.data = crc[15:8];
                word.eop  = 1'b1;
              end
            endcase
            if (out_ready) begin
              step_next = step + 4'd1;
              if (step < 4'd7) begin
                crc_next = crc_feed(crc_base, word.data);
              end
              if (step == 4'd6) begin
                bytes_left_next = len - MIN_LEN;
                if (len != MIN_LEN) begin
                  phase_next = PH_BODY;
                  step_next  = 4'd0;
                  done       = 1'b1;
                end
              end else if (step >= 4'd8) begin
                phase_next = PH_ID;
                step_next  = 4'd0;
                done       = 1'b1;
              end
            end
          end
        end
        PH_BODY: begin
          emit = 1'b1;
          case (step)
            4'd0:    word.data = item_byte;
            4'd1:    word.data = crc[7:0];
            default: begin
              word.data = crc[15:8];
              word.eop  = 1'b1;
            end
          endcase
          if (out_ready) begin
            step_next = step + 4'd1;
            if (step == 4'd0) begin
              crc_next        = crc_feed(crc, item_byte);
              bytes_left_next = bytes_left - 16'd1;
              if (bytes_left != 16'd1) begin
                step_next = 4'd0;
                done      = 1'b1;
              end
            end else if (step >= 4'd2) begin
              phase_next = PH_ID;
              step_next  = 4'd0;
              done       = 1'b1;
            end
          end
        end
        PH_DISCARD: begin
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase_next = PH_ID;
          end
          done = 1'b1;
        end
        default: begin
          held_id_next = item_byte;
          phase_next   = PH_LEN_LO;
          done         = 1'b1;
        end
      endcase
    end
  end

  // Framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID;
      held_id      <= '0;
      held_len_low <= '0;
      bytes_left   <= '0;
      crc          <= '0;
      step         <= '0;
    end else begin
      phase        <= phase_next;
      held_id      <= held_id_next;
      held_len_low <= held_len_low_next;
      bytes_left   <= bytes_left_next;
      crc          <= crc_next;
      step         <= step_next;
    end
  end

  spf_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (emit),
    .push_word     (word),
    .ready         (out_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .end_of_packet (end_of_packet),
    .status        (status)
  );

endmodule
